>>> hdl/eobd_pkg.sv
// ----------------------------------------------------------------------------
// Engine data OBD bank package
// Shared types, request codes, PID codes and helper functions for the
// engine data register bank.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package eobd_pkg;

    typedef enum logic [1:0] {
        REQ_UPDATE   = 2'd0,
        REQ_READ_ALL = 2'd1,
        REQ_READ_PID = 2'd2,
        REQ_RESERVED = 2'd3
    } t_req;

    localparam logic [31:0] NO_VALUE     = 32'hFFFF_FFFF;
    localparam logic [31:0] PID_RPM      = 32'h0000_000C;
    localparam logic [31:0] PID_SPEED    = 32'h0000_000D;
    localparam logic [31:0] PID_COOLANT  = 32'h0000_0005;
    localparam logic [31:0] PID_THROTTLE = 32'h0000_0011;
    localparam logic [31:0] PID_MAP      = 32'h0000_000B;
    localparam logic [31:0] PID_STATUS   = 32'h0000_0001;

    // Division by 37 for a 16-bit value: multiply by ceil(2^22 / 37), shift by 22.
    localparam int          SPEED_SHIFT  = 22;
    localparam int          SPEED_W      = 11;
    localparam logic [16:0] SPEED_RECIP  = 17'd113360;
    localparam logic [SPEED_W-1:0] SPEED_CAP = 11'd250;

    localparam logic [31:0] O2_MID       = 32'd450;
    localparam logic [15:0] LAMBDA_STOICH = 16'd100;

    typedef struct packed {
        logic [15:0] rpm;
        logic [15:0] coolant;
        logic [15:0] throttle;
        logic [15:0] map_kpa;
        logic [15:0] lambda;
        logic [15:0] fault;
        logic [31:0] seq;
    } t_snapshot;

    typedef struct packed {
        t_req        req;
        logic [31:0] pid;
        t_snapshot   upd;
    } t_item;

    typedef struct packed {
        logic [31:0] w0;
        logic [63:0] w1;
        logic [63:0] w2;
        logic [63:0] w3;
    } t_result;

    function automatic logic [SPEED_W-1:0] speed_of(input logic [15:0] rpm);
        logic [32:0] prod;
        prod = {17'd0, rpm} * {16'd0, SPEED_RECIP};
        return prod[SPEED_SHIFT +: SPEED_W];
    endfunction

    function automatic logic [31:0] o2_mv(input logic [15:0] lambda);
        logic [31:0] lam;
        lam = {16'd0, lambda};
        if (lambda >= LAMBDA_STOICH) begin
            return O2_MID + (lam - {16'd0, LAMBDA_STOICH}) * 32'd3;
        end
        return O2_MID - ({16'd0, LAMBDA_STOICH} - lam) * 32'd5;
    endfunction

endpackage

`default_nettype wire

>>> hdl/eobd_ifs.sv
// ----------------------------------------------------------------------------
// Engine data OBD bank channels
// Valid/ready interfaces for the request and the response channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface eobd_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [63:0] word1_in;
    logic [63:0] word2_in;
    logic [63:0] word3_in;
    logic [63:0] word4_in;

    modport source (output valid, req_type, word1_in, word2_in, word3_in, word4_in,
                    input ready);
    modport sink (input valid, req_type, word1_in, word2_in, word3_in, word4_in,
                  output ready);
endinterface

interface eobd_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] word0_out;
    logic [63:0] word1_out;
    logic [63:0] word2_out;
    logic [63:0] word3_out;

    modport source (output valid, word0_out, word1_out, word2_out, word3_out,
                    input ready);
    modport sink (input valid, word0_out, word1_out, word2_out, word3_out,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/eobd_bank.sv
// ----------------------------------------------------------------------------
// Engine data OBD bank storage
// Holds the engine snapshot and its valid flag; written by update items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eobd_bank
    import eobd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_wr_en,
    input  wire t_snapshot i_wr_data,
    output t_snapshot      o_snap,
    output logic           o_snap_valid
);

    t_snapshot r_snap;
    logic      r_snap_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap       <= '0;
            r_snap_valid <= 1'b0;
        end else if (i_wr_en) begin
            r_snap       <= i_wr_data;
            r_snap_valid <= 1'b1;
        end
    end

    assign o_snap       = r_snap;
    assign o_snap_valid = r_snap_valid;

endmodule

`default_nettype wire

>>> hdl/eobd_format.sv
// ----------------------------------------------------------------------------
// Engine data OBD bank response formatter
// Builds the response words of one item from the stored snapshot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eobd_format
    import eobd_pkg::*;
(
    input  wire t_item     i_item,
    input  wire t_snapshot i_snap,
    input  wire logic      i_snap_valid,
    output t_result        o_result
);

    logic [SPEED_W-1:0] speed_raw;
    logic [SPEED_W-1:0] speed_capped;
    logic [31:0]        o2;
    logic [31:0]        pid_val;
    logic               dtc;

    always_comb begin
        speed_raw    = speed_of(i_snap.rpm);
        speed_capped = (speed_raw > SPEED_CAP) ? SPEED_CAP : speed_raw;
        o2           = o2_mv(i_snap.lambda);
        dtc          = (i_snap.fault != 16'd0);

        if (!i_snap_valid) begin
            pid_val = NO_VALUE;
        end else if (i_item.pid == PID_RPM) begin
            pid_val = {16'd0, i_snap.rpm};
        end else if (i_item.pid == PID_SPEED) begin
            pid_val = {{(32 - SPEED_W){1'b0}}, speed_raw};
        end else if (i_item.pid == PID_COOLANT) begin
            pid_val = {16'd0, i_snap.coolant};
        end else if (i_item.pid == PID_THROTTLE) begin
            pid_val = {16'd0, i_snap.throttle};
        end else if (i_item.pid == PID_MAP) begin
            pid_val = {16'd0, i_snap.map_kpa};
        end else if (i_item.pid == PID_STATUS) begin
            pid_val = {31'd0, dtc};
        end else begin
            pid_val = NO_VALUE;
        end

        o_result = '0;
        unique case (i_item.req)
            REQ_UPDATE: begin
                o_result = '0;
            end
            REQ_READ_ALL: begin
                if (i_snap_valid) begin
                    o_result.w1 = {i_snap.throttle, i_snap.coolant,
                                   {(16 - SPEED_W){1'b0}}, speed_capped, i_snap.rpm};
                    o_result.w2 = {48'd0, i_snap.map_kpa}
                                | {16'd0, o2, 16'd0}
                                | {31'd0, dtc, 32'd0}
                                | {i_snap.fault, 48'd0};
                    o_result.w3 = {32'd0, i_snap.seq};
                end
            end
            REQ_READ_PID: begin
                o_result.w0 = pid_val;
            end
            REQ_RESERVED: begin
                o_result.w0 = NO_VALUE;
            end
            default: begin
                o_result.w0 = NO_VALUE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/engine_data_obd_register_bank.sv
// ----------------------------------------------------------------------------
// Engine data OBD register bank
// Flow: an accepted item is held in the input register; its result is written
// to the result register when the response side is free, and then offered.
// Throughput: one item per cycle unless responses stall; one input register,
// one result register. Each item gives exactly one result, in order.
// Reset: synchronous, active low; clears the snapshot and its valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module engine_data_obd_register_bank
    import eobd_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    eobd_req_if.sink    i_req,
    eobd_rsp_if.source  o_rsp
);

    logic      r_in_vld;
    t_item     r_item;
    t_item     n_item;
    logic      r_out_vld;
    t_result   r_res;
    t_result   n_res;
    logic      advance;
    logic      fire;
    logic      in_ready;
    t_snapshot snap;
    logic      snap_valid;

    assign advance  = !r_out_vld || o_rsp.ready;
    assign fire     = r_in_vld && advance;
    assign in_ready = !r_in_vld || fire;

    always_comb begin
        n_item              = '0;
        n_item.req          = t_req'(i_req.req_type);
        n_item.pid          = i_req.word1_in[31:0];
        n_item.upd.rpm      = i_req.word1_in[15:0];
        n_item.upd.coolant  = i_req.word1_in[47:32];
        n_item.upd.throttle = i_req.word1_in[63:48];
        n_item.upd.fault    = i_req.word2_in[47:32];
        n_item.upd.seq      = i_req.word3_in[31:0];
        n_item.upd.lambda   = i_req.word3_in[47:32];
        n_item.upd.map_kpa  = i_req.word4_in[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_req.valid && in_ready) begin
                r_in_vld <= 1'b1;
            end else if (fire) begin
                r_in_vld <= 1'b0;
            end
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && in_ready) begin
            r_item <= n_item;
        end
        if (fire) begin
            r_res <= n_res;
        end
    end

    eobd_bank u_bank (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (fire && (r_item.req == REQ_UPDATE)),
        .i_wr_data    (r_item.upd),
        .o_snap       (snap),
        .o_snap_valid (snap_valid)
    );

    eobd_format u_format (
        .i_item       (r_item),
        .i_snap       (snap),
        .i_snap_valid (snap_valid),
        .o_result     (n_res)
    );

    assign i_req.ready     = in_ready;
    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.word0_out = r_res.w0;
    assign o_rsp.word1_out = r_res.w1;
    assign o_rsp.word2_out = r_res.w2;
    assign o_rsp.word3_out = r_res.w3;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Engine data OBD register bank testbench
// Sends update, read-all, PID-read and reserved requests through the request
// channel and checks every response against a predictor that keeps its own
// copy of the engine snapshot. A short table of directed items comes first,
// then random items, with random idling and stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import eobd_pkg::*;

    localparam int          RANDOM_ITEMS  = 2000;
    localparam int          HOLD_AT       = 600;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          DRAIN_AT      = 1200;
    localparam int          TAIL_CYCLES   = 10;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam logic [31:0] SPEED_DIVISOR = 32'd37;
    localparam logic [31:0] O2_LEAN_SLOPE = 32'd3;
    localparam logic [31:0] O2_RICH_SLOPE = 32'd5;

    typedef struct {
        t_req        kind;
        logic [63:0] w1;
        logic [63:0] w2;
        logic [63:0] w3;
        logic [63:0] w4;
        bit          typed;
        logic [31:0] want_w0;
    } t_stim;

    logic i_clk;
    logic i_rst_n;

    eobd_req_if req_ch();
    eobd_rsp_if rsp_ch();

    engine_data_obd_register_bank i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    t_snapshot snap       = '0;
    bit        snap_valid = 1'b0;
    t_result   expected_responses[$];
    int        error_count = 0;
    int        cycle_count = 0;
    bit        hold_request = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [15:0] rand16(input int unsigned lo, input int unsigned hi);
        logic [31:0] v;
        v = $urandom_range(hi, lo);
        return v[15:0];
    endfunction

    function automatic logic [31:0] o2_reading(input logic [15:0] lambda);
        logic [31:0] lam;
        logic [31:0] stoich;
        lam = {16'd0, lambda};
        stoich = {16'd0, LAMBDA_STOICH};
        if (lam >= stoich) begin
            return O2_MID + (lam - stoich) * O2_LEAN_SLOPE;
        end
        return O2_MID - (stoich - lam) * O2_RICH_SLOPE;
    endfunction

    function automatic logic [31:0] pid_reading(input logic [31:0] pid);
        if (!snap_valid) begin
            return NO_VALUE;
        end
        case (pid)
            PID_RPM:      return {16'd0, snap.rpm};
            PID_SPEED:    return {16'd0, snap.rpm} / SPEED_DIVISOR;
            PID_COOLANT:  return {16'd0, snap.coolant};
            PID_THROTTLE: return {16'd0, snap.throttle};
            PID_MAP:      return {16'd0, snap.map_kpa};
            PID_STATUS:   return (snap.fault != 16'd0) ? 32'd1 : 32'd0;
            default:      return NO_VALUE;
        endcase
    endfunction

    function automatic t_result predict_response(input t_stim s);
        t_result     r;
        logic [31:0] speed;
        r = '0;
        case (s.kind)
            REQ_UPDATE: begin
                snap.rpm      = s.w1[15:0];
                snap.coolant  = s.w1[47:32];
                snap.throttle = s.w1[63:48];
                snap.fault    = s.w2[47:32];
                snap.seq      = s.w3[31:0];
                snap.lambda   = s.w3[47:32];
                snap.map_kpa  = s.w4[15:0];
                snap_valid    = 1'b1;
            end
            REQ_READ_ALL: begin
                if (snap_valid) begin
                    speed = {16'd0, snap.rpm} / SPEED_DIVISOR;
                    if (speed > {21'd0, SPEED_CAP}) begin
                        speed = {21'd0, SPEED_CAP};
                    end
                    r.w1 = {snap.throttle, snap.coolant, speed[15:0], snap.rpm};
                    r.w2 = {snap.fault, 48'd0}
                         | {31'd0, snap.fault != 16'd0, 32'd0}
                         | {16'd0, o2_reading(snap.lambda), 16'd0}
                         | {48'd0, snap.map_kpa};
                    r.w3 = {32'd0, snap.seq};
                end
            end
            REQ_READ_PID: begin
                r.w0 = pid_reading(s.w1[31:0]);
            end
            default: begin
                r.w0 = NO_VALUE;
            end
        endcase
        return r;
    endfunction

    function automatic t_stim make_row(input t_req kind, input logic [63:0] w1,
                                       input bit typed, input logic [31:0] want_w0);
        t_stim s;
        s.kind    = kind;
        s.w1      = w1;
        s.w2      = {$urandom, $urandom};
        s.w3      = {$urandom, $urandom};
        s.w4      = {$urandom, $urandom};
        s.typed   = typed;
        s.want_w0 = want_w0;
        return s;
    endfunction

    function automatic t_stim make_update(input logic [15:0] rpm, input logic [15:0] coolant,
                                          input logic [15:0] throttle, input logic [15:0] fault,
                                          input logic [31:0] seq, input logic [15:0] lambda,
                                          input logic [15:0] map_kpa, input bit typed);
        t_stim       s;
        logic [63:0] junk;
        logic [63:0] junk2;
        junk      = {$urandom, $urandom};
        junk2     = {$urandom, $urandom};
        s.kind    = REQ_UPDATE;
        s.w1      = {throttle, coolant, junk[15:0], rpm};
        s.w2      = {junk[63:48], fault, junk[47:16]};
        s.w3      = {junk[31:16], lambda, seq};
        s.w4      = {junk2[47:0], map_kpa};
        s.typed   = typed;
        s.want_w0 = 32'd0;
        return s;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            error_count++;
        end
    endfunction

    task automatic send_item(input t_stim s, input int gap, input bit drain);
        t_result want;
        if (drain || gap > 0) begin
            req_ch.valid <= 1'b0;
        end
        if (drain) begin
            do @(posedge i_clk); while (expected_responses.size() != 0);
        end
        repeat (gap) @(posedge i_clk);
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= s.kind;
        req_ch.word1_in <= s.w1;
        req_ch.word2_in <= s.w2;
        req_ch.word3_in <= s.w3;
        req_ch.word4_in <= s.w4;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        want = predict_response(s);
        if (s.typed) begin
            want = {s.want_w0, 64'd0, 64'd0, 64'd0};
        end
        expected_responses.push_back(want);
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin : rsp_check
        t_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_responses.size() == 0) begin
                $error("unexpected response item: word0_out=%h", rsp_ch.word0_out);
                error_count++;
            end else begin
                want = expected_responses.pop_front();
                check_field("word0_out", {32'd0, want.w0}, {32'd0, rsp_ch.word0_out});
                check_field("word1_out", want.w1, rsp_ch.word1_out);
                check_field("word2_out", want.w2, rsp_ch.word2_out);
                check_field("word3_out", want.w3, rsp_ch.word3_out);
            end
        end
    end

    initial begin
        int stall;
        int taken;
        bit rx_steady;
        taken = 0;
        rx_steady = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                stall = HOLD_CYCLES;
            end else if (rx_steady) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 8);
            end
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid) @(posedge i_clk);
            taken++;
            if (taken % 150 == 0) begin
                rx_steady = ($urandom_range(0, 3) == 0);
            end
        end
    end

    initial begin
        t_stim       rows[$];
        t_stim       item;
        int          gap;
        int          pick;
        int          steady_left;
        bit          tx_steady;
        logic [15:0] rpm;
        logic [15:0] lambda;
        logic [15:0] fault;
        logic [31:0] pid;

        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_UPDATE;
        req_ch.word1_in <= '0;
        req_ch.word2_in <= '0;
        req_ch.word3_in <= '0;
        req_ch.word4_in <= '0;
        i_rst_n         <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows.push_back(make_row(REQ_READ_ALL, '1, 1'b1, 32'd0));
        rows.push_back(make_row(REQ_READ_PID, {32'd0, PID_RPM}, 1'b1, NO_VALUE));
        rows.push_back(make_row(REQ_READ_PID, {32'd0, PID_STATUS}, 1'b1, NO_VALUE));
        rows.push_back(make_row(REQ_RESERVED, '0, 1'b1, NO_VALUE));
        item = make_row(REQ_UPDATE, '1, 1'b1, 32'd0);
        item.w2 = '1;
        item.w3 = '1;
        item.w4 = '1;
        rows.push_back(item);
        rows.push_back(make_row(REQ_READ_ALL, '0, 1'b0, 32'd0));
        rows.push_back(make_row(REQ_READ_PID, {32'd0, PID_RPM}, 1'b0, 32'd0));
        rows.push_back(make_row(REQ_READ_PID, {32'd0, PID_SPEED}, 1'b0, 32'd0));
        rows.push_back(make_row(REQ_READ_PID, {32'd0, PID_COOLANT}, 1'b0, 32'd0));
        rows.push_back(make_row(REQ_READ_PID, {32'd0, PID_THROTTLE}, 1'b0, 32'd0));
        rows.push_back(make_row(REQ_READ_PID, {32'd0, PID_MAP}, 1'b0, 32'd0));
        rows.push_back(make_row(REQ_READ_PID, {32'd0, PID_STATUS}, 1'b0, 32'd0));
        rows.push_back(make_row(REQ_READ_PID, {32'hFFFF_FFFF, PID_SPEED}, 1'b0, 32'd0));
        rows.push_back(make_row(REQ_READ_PID, {32'd0, 32'hFFFF_FFFF}, 1'b1, NO_VALUE));
        rows.push_back(make_row(REQ_RESERVED, '1, 1'b1, NO_VALUE));
        item = make_row(REQ_UPDATE, '0, 1'b1, 32'd0);
        item.w2 = '0;
        item.w3 = '0;
        item.w4 = '0;
        rows.push_back(item);
        rows.push_back(make_row(REQ_READ_ALL, '0, 1'b0, 32'd0));
        rows.push_back(make_row(REQ_READ_PID, {32'd0, PID_STATUS}, 1'b0, 32'd0));
        rows.push_back(make_update(16'd9287, 16'd90, 16'd40, 16'd1, 32'd7, 16'd9, 16'd101,
                                   1'b1));
        rows.push_back(make_row(REQ_READ_ALL, '0, 1'b0, 32'd0));
        rows.push_back(make_row(REQ_READ_PID, {32'd0, PID_SPEED}, 1'b0, 32'd0));
        rows.push_back(make_update(16'd9250, 16'd85, 16'd12, 16'd0, 32'd8, 16'd10, 16'd35,
                                   1'b1));
        rows.push_back(make_row(REQ_READ_ALL, '0, 1'b0, 32'd0));
        rows.push_back(make_update(16'd37, 16'd20, 16'd0, 16'h8000, 32'd9, 16'd99, 16'd99,
                                   1'b1));
        rows.push_back(make_row(REQ_READ_ALL, '0, 1'b0, 32'd0));
        rows.push_back(make_update(16'd800, 16'd95, 16'd100, 16'd3, 32'd10, 16'd100, 16'd60,
                                   1'b1));
        rows.push_back(make_row(REQ_READ_ALL, '0, 1'b0, 32'd0));

        foreach (rows[i]) begin
            gap = $urandom_range(0, 8);
            send_item(rows[i], gap, 1'b0);
        end

        tx_steady = 1'b0;
        steady_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0) begin
                tx_steady = ($urandom_range(0, 3) == 0);
            end
            if (n == HOLD_AT) begin
                hold_request = 1'b1;
                steady_left = 40;
            end
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                case ($urandom_range(0, 3))
                    0:       rpm = rand16(9200, 9330);
                    1:       rpm = rand16(0, 80);
                    default: rpm = rand16(0, 16'hFFFF);
                endcase
                case ($urandom_range(0, 3))
                    0:       lambda = rand16(0, 15);
                    1:       lambda = rand16(90, 110);
                    default: lambda = rand16(0, 16'hFFFF);
                endcase
                fault = ($urandom_range(0, 2) == 0) ? 16'd0 : rand16(0, 16'hFFFF);
                item = make_update(rpm, rand16(0, 16'hFFFF), rand16(0, 16'hFFFF), fault,
                                   $urandom, lambda, rand16(0, 16'hFFFF), 1'b0);
            end else if (pick < 60) begin
                item = make_row(REQ_READ_ALL, {$urandom, $urandom}, 1'b0, 32'd0);
            end else if (pick < 95) begin
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    case ($urandom_range(0, 5))
                        0:       pid = PID_RPM;
                        1:       pid = PID_SPEED;
                        2:       pid = PID_COOLANT;
                        3:       pid = PID_THROTTLE;
                        4:       pid = PID_MAP;
                        default: pid = PID_STATUS;
                    endcase
                end else if (pick < 90) begin
                    pid = $urandom_range(0, 31);
                end else begin
                    pid = $urandom;
                end
                item = make_row(REQ_READ_PID, {$urandom, pid}, 1'b0, 32'd0);
            end else begin
                item = make_row(REQ_RESERVED, {$urandom, $urandom}, 1'b0, 32'd0);
            end
            gap = (tx_steady || steady_left > 0) ? 0 : $urandom_range(0, 8);
            if (steady_left > 0) begin
                steady_left--;
            end
            send_item(item, gap, n == DRAIN_AT);
        end
        req_ch.valid <= 1'b0;

        while (expected_responses.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/eobd_pkg.sv
hdl/eobd_ifs.sv
hdl/eobd_bank.sv
hdl/eobd_format.sv
hdl/engine_data_obd_register_bank.sv
tb/tb_top.sv
